@@ hw/rtl/fdr_pkg.sv @@
// fdr_pkg: shared types and constants for the fresnel dielectric reflectance unit
// no dependencies
`timescale 1ns / 1ps
package fdr_pkg;
	localparam int ETA_W = 16;
	localparam int REFL_W = 16;
	localparam logic [0:0] REG_ETA_INCIDENT = 1'b0;
	localparam logic [0:0] REG_ETA_TRANSMIT = 1'b1;
	localparam logic [15:0] ETA_I_RESET = 16'd4096;
	localparam logic [15:0] ETA_T_RESET = 16'd6144;
	localparam logic [15:0] REFL_ONE = 16'd32768;
	// sideband that rides along the pipeline
	typedef struct packed {
		logic tir;
	} fdr_flags_t;
endpackage

@@ hw/rtl/fdr_div.sv @@
// fdr_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing
`timescale 1ns / 1ps
module fdr_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int QW = 17,
	parameter int TW = 34
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	// quotient bits from QW-1 downto 0; numerator assumed below den * 2^QW
	logic [NW-1:0] rem_s1 [QW+1];
	logic [DW-1:0] den_s1 [QW+1];
	logic [QW-1:0] q_s1   [QW+1];
	logic [TW-1:0] tag_s1 [QW+1];

	always_comb begin
		rem_s1[0] = num;
		den_s1[0] = den;
		q_s1[0] = '0;
		tag_s1[0] = tag_in;
	end

	for (genvar i = 0; i < QW; i++) begin : g_st
		localparam int B = QW - 1 - i;
		logic [NW+QW-1:0] trial;
		logic             ge;
		assign trial = {{QW{1'b0}}, den_s1[i]} << B;
		assign ge = {{QW{1'b0}}, rem_s1[i]} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s1[i+1] <= ge ? rem_s1[i] - trial[NW-1:0] : rem_s1[i];
				den_s1[i+1] <= den_s1[i];
				q_s1[i+1] <= q_s1[i] | (QW'(ge) << B);
				tag_s1[i+1] <= tag_s1[i];
			end
		end
	end
	assign quo = q_s1[QW];
	assign tag_out = tag_s1[QW];
endmodule

@@ hw/rtl/fdr_sqrt.sv @@
// fdr_sqrt: pipelined integer square root, one result bit per stage
// depends on nothing
`timescale 1ns / 1ps
module fdr_sqrt #(
	parameter int VW = 34,
	parameter int TW = 34
) (
	input  logic            clk,
	input  logic            en,
	input  logic [VW-1:0]   val,
	input  logic [TW-1:0]   tag_in,
	output logic [VW/2:0]   root,
	output logic [TW-1:0]   tag_out
);
	localparam int RW = VW / 2 + 1;
	logic [VW+1:0]  v_s1   [RW+1];
	logic [RW-1:0]  r_s1   [RW+1];
	logic [TW-1:0]  tag_s1 [RW+1];

	always_comb begin
		v_s1[0] = {2'b00, val};
		r_s1[0] = '0;
		tag_s1[0] = tag_in;
	end

	for (genvar i = 0; i < RW; i++) begin : g_st
		localparam int B = RW - 1 - i;
		logic [VW+1:0] cand;
		// (2r + 2^B) * 2^B with r built from higher bits
		assign cand = ({{(VW+2-RW){1'b0}}, r_s1[i]} << (B + 1))
			+ ((VW+2)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s1[i] >= cand) begin
					v_s1[i+1] <= v_s1[i] - cand;
					r_s1[i+1] <= r_s1[i] | (RW'(1) << B);
				end else begin
					v_s1[i+1] <= v_s1[i];
					r_s1[i+1] <= r_s1[i];
				end
				tag_s1[i+1] <= tag_s1[i];
			end
		end
	end
	assign root = r_s1[RW];
	assign tag_out = tag_s1[RW];
endmodule

@@ hw/rtl/fresnel_dielectric_reflectance_unit.sv @@
// fresnel_dielectric_reflectance_unit: top level of the reflectance pipeline
// depends on fdr_pkg, fdr_div, fdr_sqrt
`timescale 1ns / 1ps
// usage
// - s_axis carries one cosine per transfer (tdata = cos_incidence, signed)
// - m_axis returns one result per transfer (tdata = reflectance, tuser = total_internal)
// - cfg_we/cfg_index/cfg_data write eta_incident (0) and eta_transmit (1), Q4.12
// - one item per cycle sustained while m_axis_tready stays high; from the input
//   transfer to m_axis_tvalid the data passes four front stages (clamp and swap,
//   squares, sine product, tir test), the pipelined transmitted-cosine divider
//   (33 stages), the square root (18 stages), two product and ratio stages,
//   the two ratio dividers (17 stages), the square stage and the output register
// - the whole pipeline advances together: while a result waits on m_axis_tready
//   every stage holds and s_axis_tready is low, so nothing is dropped or
//   repeated; s_axis_tready follows m_axis_tready combinationally in that case
//   and is high whenever the output register is empty
// - reset clears all valid bits and loads the index registers with 1.0 and 1.5
// - write configuration only while the pipeline is empty
module fresnel_dielectric_reflectance_unit #(
	parameter int COS_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] cos_incidence
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] reflectance
	output logic        m_axis_tuser,   // [0] total_internal
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int D1 = 33; // divider stages for cos^2 transmitted
	localparam int SQ = 18; // sqrt stages (34-bit value, 18 root bits)
	localparam int D2 = 17; // ratio divider stages
	localparam int LAT = 4 + D1 + SQ + 1 + 1 + D2 + 2;

	logic [15:0] eta_i_q, eta_t_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_i_q <= fdr_pkg::ETA_I_RESET;
			eta_t_q <= fdr_pkg::ETA_T_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fdr_pkg::REG_ETA_INCIDENT: eta_i_q <= cfg_data;
				fdr_pkg::REG_ETA_TRANSMIT: eta_t_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global stall: pipeline moves when output is empty or being taken
	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
	end

	// stage 1: clamp, swap, scale to Q.16
	localparam int CF = COS_FRAC_BITS;
	localparam int CW = CF + 2;
	logic signed [CW-1:0] lim;
	logic signed [15:0] c_in;
	logic [CW-1:0] mag;
	logic [16:0] ck;
	logic sw;
	logic [CW+16:0] ck_w;
	assign lim = CW'(1) <<< CF;
	assign c_in = s_axis_tdata;
	always_comb begin
		logic signed [CW-1:0] cc;
		if (CW'(c_in) > lim && CW >= 16) cc = lim;
		else if (CW'(c_in) < -lim && CW >= 16) cc = -lim;
		else cc = CW'(c_in);
		if (CW < 16) begin
			if ($signed({{16{c_in[15]}}, c_in}) > $signed(32'(lim))) cc = lim;
			else if ($signed({{16{c_in[15]}}, c_in}) < -$signed(32'(lim))) cc = -lim;
		end
		sw = (cc <= 0);
		mag = sw ? CW'(-cc) : CW'(cc);
		if (CF >= 16) ck_w = (CW+17)'(mag) >> (CF - 16);
		else ck_w = (CW+17)'(mag) << (16 - CF);
		ck = (ck_w > (CW+17)'(65536)) ? 17'd65536 : ck_w[16:0];
	end

	logic [15:0] ei_s1, et_s1;
	logic [16:0] ck_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ei_s1 <= sw ? eta_t_q : eta_i_q;
			et_s1 <= sw ? eta_i_q : eta_t_q;
			ck_s1 <= ck;
		end
	end
	// zero index is replaced by the smallest nonzero code (one LSB)
	logic [15:0] ei1, et1;
	assign ei1 = (ei_s1 == 16'd0) ? 16'd1 : ei_s1;
	assign et1 = (et_s1 == 16'd0) ? 16'd1 : et_s1;

	// stage 2: squares
	logic [31:0] ei2_s2, et2_s2;
	logic [32:0] s2_s2;
	logic [15:0] ei_s2, et_s2;
	logic [16:0] ck_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			ei2_s2 <= 32'(ei1) * 32'(ei1);
			et2_s2 <= 32'(et1) * 32'(et1);
			s2_s2 <= 33'h1_0000_0000 - 33'(ck_s1) * 33'(ck_s1);
			ei_s2 <= ei1; et_s2 <= et1; ck_s2 <= ck_s1;
		end
	end

	// stage 3: ei^2 * s2 split in a low 17-bit and a high 16-bit part
	logic [48:0] lo_s3;
	logic [31:0] ei2_s3, et2_s3;
	logic [15:0] ei_s3, et_s3;
	logic [16:0] ck_s3;
	logic [15:0] s2m_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3 <= 49'(ei2_s2) * 49'(s2_s2[16:0]);
			s2m_s3 <= s2_s2[32:17];
			ei2_s3 <= ei2_s2; et2_s3 <= et2_s2;
			ei_s3 <= ei_s2; et_s3 <= et_s2; ck_s3 <= ck_s2;
		end
	end
	logic [47:0] midp;
	assign midp = 48'(ei2_s3) * 48'(s2m_s3);

	// stage 4: tir test and numerator
	logic [64:0] lhs, rhs;
	logic [63:0] num_s4;
	logic [31:0] et2_s4;
	logic tir_s4;
	logic [15:0] ei_s4, et_s4;
	logic [16:0] ck_s4;
	assign lhs = 65'(lo_s3) + (65'(midp) << 17);
	assign rhs = 65'(et2_s3) << 32;
	always_ff @(posedge clk) begin
		if (en) begin
			tir_s4 <= lhs >= rhs;
			num_s4 <= (lhs >= rhs) ? 64'd0 : 64'(rhs - lhs);
			et2_s4 <= et2_s3;
			ei_s4 <= ei_s3; et_s4 <= et_s3; ck_s4 <= ck_s3;
		end
	end

	// quotient <= 2^32 since num <= et^2 * 2^32; 33 bits
	localparam int TG = 1 + 16 + 16 + 17;
	logic [32:0] c2t;
	logic [TG-1:0] tg_d1;
	fdr_div #(.NW(64), .DW(32), .QW(D1), .TW(TG)) u_div_c2t (
		.clk(clk), .en(en),
		.num(num_s4), .den(et2_s4),
		.tag_in({tir_s4, ei_s4, et_s4, ck_s4}),
		.quo(c2t), .tag_out(tg_d1)
	);
	logic [17:0] ct;
	logic [TG-1:0] tg_sq;
	fdr_sqrt #(.VW(34), .TW(TG)) u_sqrt (
		.clk(clk), .en(en),
		.val({1'b0, c2t}), .tag_in(tg_d1),
		.root(ct), .tag_out(tg_sq)
	);

	// products for both ratios
	logic tir_a;
	logic [15:0] ei_a, et_a;
	logic [16:0] ck_a;
	assign {tir_a, ei_a, et_a, ck_a} = tg_sq;
	logic [32:0] x1_s5, y1_s5, x2_s5, y2_s5;
	logic tir_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s5 <= 33'(et_a) * 33'(ck_a);
			y1_s5 <= 33'(ei_a) * 33'(ct[16:0]);
			x2_s5 <= 33'(ei_a) * 33'(ck_a);
			y2_s5 <= 33'(et_a) * 33'(ct[16:0]);
			tir_s5 <= tir_a;
		end
	end
	logic [33:0] sa_s6, ra_s6, sb_s6, rb_s6;
	logic tir_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			sa_s6 <= 34'(x1_s5) + 34'(y1_s5);
			ra_s6 <= (x1_s5 > y1_s5) ? 34'(x1_s5 - y1_s5) : 34'(y1_s5 - x1_s5);
			sb_s6 <= 34'(x2_s5) + 34'(y2_s5);
			rb_s6 <= (x2_s5 > y2_s5) ? 34'(x2_s5 - y2_s5) : 34'(y2_s5 - x2_s5);
			tir_s6 <= tir_s5;
		end
	end
	// ratio <= 1 so 17 quotient bits; zero sum gives ratio one
	logic [16:0] qa, qb;
	logic [1:0] tga;
	logic tgb;
	fdr_div #(.NW(50), .DW(34), .QW(D2), .TW(2)) u_div_a (
		.clk(clk), .en(en),
		.num({ra_s6, 16'd0}), .den(sa_s6 == 34'd0 ? 34'd1 : sa_s6),
		.tag_in({tir_s6, sa_s6 == 34'd0}),
		.quo(qa), .tag_out(tga)
	);
	fdr_div #(.NW(50), .DW(34), .QW(D2), .TW(1)) u_div_b (
		.clk(clk), .en(en),
		.num({rb_s6, 16'd0}), .den(sb_s6 == 34'd0 ? 34'd1 : sb_s6),
		.tag_in(sb_s6 == 34'd0), .quo(qb), .tag_out(tgb)
	);
	logic [16:0] qa1, qb1;
	assign qa1 = tga[0] ? 17'h10000 : qa;
	assign qb1 = tgb ? 17'h10000 : qb;

	logic [33:0] pa_s7, pb_s7;
	logic tir_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s7 <= 34'(qa1) * 34'(qa1);
			pb_s7 <= 34'(qb1) * 34'(qb1);
			tir_s7 <= tga[1];
		end
	end
	logic [34:0] sum;
	logic [16:0] refl;
	assign sum = 35'(pa_s7) + 35'(pb_s7) + 35'(1 << 17);
	assign refl = sum[34:18];

	fdr_pkg::fdr_flags_t fl_q;
	logic [15:0] refl_q;
	always_ff @(posedge clk) begin
		if (en) begin
			fl_q.tir <= tir_s7;
			refl_q <= (tir_s7 || refl > 17'd32768) ? fdr_pkg::REFL_ONE : refl[15:0];
		end
	end
	assign m_axis_tvalid = vld_q[LAT-1];
	assign m_axis_tdata = refl_q;
	assign m_axis_tuser = fl_q.tir;
endmodule

@@ hw/rtl/fdr_checker.sv @@
// fdr_checker: port-level assertions for the reflectance unit
// depends on fresnel_dielectric_reflectance_unit (bound below)
`timescale 1ns / 1ps
module fdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata <= 16'd32768) else $error("reflectance above one");
	a_tir: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == 16'd32768)
		else $error("tir without full reflectance");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready) else $error("input taken on stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output dropped on stall");
endmodule

bind fresnel_dielectric_reflectance_unit fdr_checker u_fdr_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

@@ dv/tb.sv @@
// tb: self-checking bench for fresnel_dielectric_reflectance_unit
// predicts each reflectance from the cosine and the index registers; needs fdr_pkg
`timescale 1ns / 1ps
module tb;
	localparam int COS_FB = 14;
	localparam int PIPE_LAT = 120;         // generous over the 76 stage pipeline
	localparam int CYCLE_LIMIT = 1500000;
	localparam int HOLD_LEN = 300;

	typedef struct packed {
		logic [15:0] refl;
		logic        tir;
	} refl_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// model copy of the index registers
	logic [15:0] eta_i_model = fdr_pkg::ETA_I_RESET;
	logic [15:0] eta_t_model = fdr_pkg::ETA_T_RESET;

	refl_result_t pending_q[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_recv = 1'b0;
	int hold_cycles = 0;
	bit failed = 1'b0;
	int cycle_cnt = 0;

	always #10 clk = ~clk;

	fresnel_dielectric_reflectance_unit #(.COS_FRAC_BITS(COS_FB)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// floor square root, bit by bit
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// squared amplitude ratio, ratio truncated to Q.16, square in Q.32
	function automatic longint unsigned amp_ratio_sq(input longint unsigned x,
			input longint unsigned y);
		longint unsigned s, d, q;
		s = x + y;
		d = (x > y) ? x - y : y - x;
		if (s == 0) return 64'd1 << 32;
		q = (d << 16) / s;
		return q * q;
	endfunction

	function automatic refl_result_t fresnel_predict(input logic [15:0] raw);
		refl_result_t r;
		longint signed c, lim;
		longint unsigned ei, et, tmp, mag, ck, s2, lhs, rhs, c2t, ct, sum, refl;
		c = longint'($signed(raw));
		lim = 64'sd1 << COS_FB;
		ei = (eta_i_model == 0) ? 1 : eta_i_model;
		et = (eta_t_model == 0) ? 1 : eta_t_model;
		if (c > lim) c = lim;
		if (c < -lim) c = -lim;
		// non-positive cosine: ray leaves the medium, indices trade places
		if (c <= 0) begin
			tmp = ei; ei = et; et = tmp;
			mag = longint'(-c);
		end else begin
			mag = c;
		end
		ck = mag << (16 - COS_FB);
		if (ck > 65536) ck = 65536;
		s2 = (64'd1 << 32) - ck * ck;
		lhs = ei * ei * s2;
		rhs = (et * et) << 32;
		if (lhs >= rhs) begin
			r.refl = fdr_pkg::REFL_ONE;
			r.tir = 1'b1;
			return r;
		end
		c2t = (rhs - lhs) / (et * et);
		ct = floor_sqrt(c2t);
		sum = amp_ratio_sq(et * ck, ei * ct) + amp_ratio_sq(ei * ck, et * ct);
		refl = (sum + (64'd1 << 17)) >> 18;
		if (refl > 32768) refl = 32768;
		r.refl = refl[15:0];
		r.tir = 1'b0;
		return r;
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// hold-off counter for the long receiver stall
	always @(posedge clk) begin
		if (hold_recv && hold_cycles < HOLD_LEN) hold_cycles <= hold_cycles + 1;
	end

	// receiver: random stalls, or a forced hold-off
	always @(posedge clk) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else if (hold_recv && hold_cycles < HOLD_LEN) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result checker: each transfer against the oldest prediction
	always @(posedge clk) begin
		refl_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result refl=%0d tir=%0d", $time,
					m_axis_tdata, m_axis_tuser);
				failed = 1'b1;
			end else begin
				exp_r = pending_q.pop_front();
				if (m_axis_tdata !== exp_r.refl) begin
					$display("%0t: reflectance expected %0d actual %0d", $time,
						exp_r.refl, m_axis_tdata);
					failed = 1'b1;
				end
				if (m_axis_tuser !== exp_r.tir) begin
					$display("%0t: total_internal expected %0d actual %0d", $time,
						exp_r.tir, m_axis_tuser);
					failed = 1'b1;
				end
			end
		end
	end

	// offer one cosine, predict at the transfer; valid stays up for the next one
	task automatic send_cos(input logic [15:0] cosv);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= cosv;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_q.push_back(fresnel_predict(cosv));
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	// write one index register, pipeline empty
	task automatic write_eta(input logic [0:0] idx, input logic [15:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == fdr_pkg::REG_ETA_INCIDENT) eta_i_model = val;
		else eta_t_model = val;
	endtask

	// random cosine, mostly in range, some out of range
	function automatic logic [15:0] rand_cos();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
			2: return 16'($urandom_range(20));
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	task automatic test_directed;
		logic [15:0] pts[$];
		pts = '{16'h0000, 16'h0001, 16'hFFFF, 16'd16384, -16'sd16384, 16'h7FFF,
			16'h8000, 16'd8192, -16'sd8192, 16'd16383, -16'sd16383, 16'h5555,
			16'hAAAA, 16'd100, -16'sd100, 16'd1000};
		foreach (pts[i]) send_cos(pts[i]);
	endtask

	task automatic test_random(input int n);
		repeat (n) send_cos(rand_cos());
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure;
		hold_recv = 1'b1;
		test_random(200);
		hold_recv = 1'b0;
	endtask

	// index settings, extremes included
	task automatic test_eta_settings;
		logic [15:0] ei_set[6] = '{16'd1, 16'hFFFF, 16'd6144, 16'd0, 16'd4096, 16'd5461};
		logic [15:0] et_set[6] = '{16'hFFFF, 16'd1, 16'd4096, 16'd4096, 16'd0, 16'd9000};
		for (int k = 0; k < 6; k++) begin
			write_eta(fdr_pkg::REG_ETA_INCIDENT, ei_set[k]);
			write_eta(fdr_pkg::REG_ETA_TRANSMIT, et_set[k]);
			test_directed();
			test_random(60);
		end
		for (int k = 0; k < 4; k++) begin
			write_eta(fdr_pkg::REG_ETA_INCIDENT, 16'($urandom_range(65535, 1)));
			write_eta(fdr_pkg::REG_ETA_TRANSMIT, 16'($urandom_range(65535, 1)));
			test_random(60);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250);
		send_idle_pct = 85;
		test_random(150);
		send_idle_pct = 0; recv_stall_pct = 85;
		test_random(150);
		send_idle_pct = 14; recv_stall_pct = 14;
		test_random(150);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_backpressure();
		recv_stall_pct = 14;
		test_eta_settings();
		drain();
		if (!failed) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_div.sv
hw/rtl/fdr_sqrt.sv
hw/rtl/fresnel_dielectric_reflectance_unit.sv
hw/rtl/fdr_checker.sv
dv/tb.sv
